### rtl/aqim_pkg.sv
package aqim_pkg;

  localparam int FRAC_BITS = 4;
  localparam int SCALE     = 1 << FRAC_BITS;
  localparam int NUM_POLL  = 5;
  localparam int NUM_BP    = 8;
  localparam int NUM_SEG   = NUM_BP - 1;
  localparam int SEG_W     = 3;

  localparam int CONC_W = 12;
  localparam int CO_W   = 10;
  localparam int OUT_W  = 13;

  localparam int TOP_INDEX = 500;
  localparam int IDX_W     = $clog2(TOP_INDEX * SCALE + 1);

  // widest segment is 800 units, widest index step is 100 (< 2^7)
  localparam int DIFF_W  = 10;
  localparam int SPAN_W  = 7;
  localparam int NUM_W   = FRAC_BITS + SPAN_W + DIFF_W;
  localparam int QUO_W   = FRAC_BITS + SPAN_W;

  // reciprocal is floor(2^K / width); numerator stays below 2^K, so the
  // estimated quotient is short by at most one
  localparam int RECIP_K = NUM_W;
  localparam int RECIP_W = RECIP_K - 4;
  localparam int ONE_K   = 1 << RECIP_K;
  localparam int PROD_W  = NUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CONC_W-1:0] CONC_BP [NUM_POLL][NUM_BP] = '{
    '{12'd0, 12'd50, 12'd150, 12'd475, 12'd800, 12'd1600, 12'd2100, 12'd2620},
    '{12'd0, 12'd40, 12'd80,  12'd180, 12'd280, 12'd565,  12'd750,  12'd940},
    '{12'd0, 12'd50, 12'd150, 12'd250, 12'd350, 12'd420,  12'd500,  12'd600},
    '{12'd0, 12'd20, 12'd40,  12'd140, 12'd240, 12'd360,  12'd480,  12'd600},
    '{12'd0, 12'd35, 12'd75,  12'd115, 12'd150, 12'd250,  12'd350,  12'd500}
  };

  localparam logic [DIFF_W-1:0] SEG_DIV [NUM_POLL][NUM_SEG] = '{
    '{10'd50, 10'd100, 10'd325, 10'd325, 10'd800, 10'd500, 10'd520},
    '{10'd40, 10'd40,  10'd100, 10'd100, 10'd285, 10'd185, 10'd190},
    '{10'd50, 10'd100, 10'd100, 10'd100, 10'd70,  10'd80,  10'd100},
    '{10'd20, 10'd20,  10'd100, 10'd100, 10'd120, 10'd120, 10'd120},
    '{10'd35, 10'd40,  10'd40,  10'd35,  10'd100, 10'd100, 10'd150}
  };

  localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_POLL][NUM_SEG] = '{
    '{RECIP_W'(ONE_K / 50),  RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 325),
      RECIP_W'(ONE_K / 325), RECIP_W'(ONE_K / 800), RECIP_W'(ONE_K / 500),
      RECIP_W'(ONE_K / 520)},
    '{RECIP_W'(ONE_K / 40),  RECIP_W'(ONE_K / 40),  RECIP_W'(ONE_K / 100),
      RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 285), RECIP_W'(ONE_K / 185),
      RECIP_W'(ONE_K / 190)},
    '{RECIP_W'(ONE_K / 50),  RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 100),
      RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 70),  RECIP_W'(ONE_K / 80),
      RECIP_W'(ONE_K / 100)},
    '{RECIP_W'(ONE_K / 20),  RECIP_W'(ONE_K / 20),  RECIP_W'(ONE_K / 100),
      RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 120), RECIP_W'(ONE_K / 120),
      RECIP_W'(ONE_K / 120)},
    '{RECIP_W'(ONE_K / 35),  RECIP_W'(ONE_K / 40),  RECIP_W'(ONE_K / 40),
      RECIP_W'(ONE_K / 35),  RECIP_W'(ONE_K / 100), RECIP_W'(ONE_K / 100),
      RECIP_W'(ONE_K / 150)}
  };

  // index at the low end of each segment, and the index step across it
  localparam logic [8:0] IDX_LO [NUM_SEG] = '{
    9'd0, 9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400
  };
  localparam logic [SPAN_W-1:0] SEG_SPAN [NUM_SEG] = '{
    7'd50, 7'd50, 7'd50, 7'd50, 7'd100, 7'd100, 7'd100
  };

  typedef struct packed {
    logic [IDX_W-1:0] base;
    logic [NUM_W-1:0] num;
    logic [SEG_W-1:0] seg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_POLL-1:0] lane;
    logic                 over;
  } work_t;

endpackage

### rtl/aqim_front.sv
module aqim_front (
  input  logic [aqim_pkg::CONC_W-1:0] so2_ugm3_i,
  input  logic [aqim_pkg::CONC_W-1:0] no2_ugm3_i,
  input  logic [aqim_pkg::CONC_W-1:0] pm10_ugm3_i,
  input  logic [aqim_pkg::CO_W-1:0]   co_tenth_mgm3_i,
  input  logic [aqim_pkg::CONC_W-1:0] pm25_ugm3_i,
  output aqim_pkg::work_t             work_o
);

  logic [aqim_pkg::CONC_W-1:0] conc    [aqim_pkg::NUM_POLL];
  logic [aqim_pkg::SEG_W-1:0]  seg_idx [aqim_pkg::NUM_POLL];
  logic [aqim_pkg::DIFF_W-1:0] offs    [aqim_pkg::NUM_POLL];

  assign conc[0] = so2_ugm3_i;
  assign conc[1] = no2_ugm3_i;
  assign conc[2] = pm10_ugm3_i;
  assign conc[3] = aqim_pkg::CONC_W'(co_tenth_mgm3_i);
  assign conc[4] = pm25_ugm3_i;

  always_comb begin
    work_o = '0;
    for (int p = 0; p < aqim_pkg::NUM_POLL; p++) begin
      // lowest segment whose upper breakpoint still covers the sample
      seg_idx[p] = aqim_pkg::SEG_W'(aqim_pkg::NUM_SEG - 1);
      for (int k = aqim_pkg::NUM_SEG - 1; k >= 0; k--) begin
        if (conc[p] <= aqim_pkg::CONC_BP[p][k+1]) begin
          seg_idx[p] = aqim_pkg::SEG_W'(k);
        end
      end
      offs[p] = aqim_pkg::DIFF_W'(conc[p] - aqim_pkg::CONC_BP[p][seg_idx[p]]);

      if (conc[p] == '0) begin
        work_o.lane[p] = '0;
      end else if (conc[p] > aqim_pkg::CONC_BP[p][aqim_pkg::NUM_BP-1]) begin
        // saturate: base carries the full top index, nothing to interpolate
        work_o.lane[p].base = aqim_pkg::IDX_W'(aqim_pkg::TOP_INDEX * aqim_pkg::SCALE);
        work_o.lane[p].num  = '0;
        work_o.lane[p].seg  = '0;
        work_o.over         = 1'b1;
      end else begin
        work_o.lane[p].base =
          aqim_pkg::IDX_W'(aqim_pkg::IDX_LO[seg_idx[p]]) << aqim_pkg::FRAC_BITS;
        work_o.lane[p].num  =
          (aqim_pkg::NUM_W'(offs[p]) * aqim_pkg::NUM_W'(aqim_pkg::SEG_SPAN[seg_idx[p]]))
          << aqim_pkg::FRAC_BITS;
        work_o.lane[p].seg  = seg_idx[p];
      end
    end
  end

endmodule

### rtl/aqim_queue.sv
module aqim_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aqim_pkg::work_t push_word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output aqim_pkg::work_t pop_word_o
);

  aqim_pkg::work_t             mem [aqim_pkg::QUEUE_DEPTH];
  logic [aqim_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [aqim_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [aqim_pkg::QCNT_W-1:0] count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o     = (count_q == aqim_pkg::QCNT_W'(aqim_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_word_o = mem[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

### rtl/aqim_back.sv
module aqim_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  aqim_pkg::work_t            work_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [aqim_pkg::OUT_W-1:0] index_sixteenths_o,
  output logic                       over_range_o
);

  localparam int NP = aqim_pkg::NUM_POLL;

  logic advance;

  // stage 1: numerator times reciprocal
  logic                         v1_q;
  logic                         over1_q;
  logic [aqim_pkg::PROD_W-1:0]  prod1_q [NP];
  logic [aqim_pkg::NUM_W-1:0]   num1_q  [NP];
  logic [aqim_pkg::IDX_W-1:0]   base1_q [NP];
  logic [aqim_pkg::SEG_W-1:0]   seg1_q  [NP];

  // stage 2: estimated quotient times segment width
  logic                         v2_q;
  logic                         over2_q;
  logic [aqim_pkg::QUO_W-1:0]   quo_est [NP];
  logic [aqim_pkg::QUO_W-1:0]   quo2_q  [NP];
  logic [aqim_pkg::NUM_W-1:0]   chk2_q  [NP];
  logic [aqim_pkg::NUM_W-1:0]   num2_q  [NP];
  logic [aqim_pkg::DIFF_W-1:0]  div2_q  [NP];
  logic [aqim_pkg::IDX_W-1:0]   base2_q [NP];

  // stage 3: corrected sub-index
  logic                         v3_q;
  logic                         over3_q;
  logic                         fix     [NP];
  logic [aqim_pkg::IDX_W-1:0]   sub3_q  [NP];

  // output word
  logic                         out_v_q;
  logic [aqim_pkg::IDX_W-1:0]   best;
  logic [aqim_pkg::IDX_W-1:0]   best_q;
  logic                         over_q;

  // the whole line moves unless the output word is held
  assign advance = !out_v_q || !out_stall_i;
  assign pop_o   = advance && valid_i;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      quo_est[p] = aqim_pkg::QUO_W'(prod1_q[p] >> aqim_pkg::RECIP_K);
      fix[p]     = ({1'b0, num2_q[p]} >=
                    ({1'b0, chk2_q[p]} + (aqim_pkg::NUM_W + 1)'(div2_q[p])));
    end
    best = sub3_q[0];
    for (int p = 1; p < NP; p++) begin
      if (sub3_q[p] > best) begin
        best = sub3_q[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      over1_q <= work_i.over;
      over2_q <= over1_q;
      over3_q <= over2_q;
      over_q  <= over3_q;
      best_q  <= best;
      for (int p = 0; p < NP; p++) begin
        prod1_q[p] <= aqim_pkg::PROD_W'(work_i.lane[p].num) *
                      aqim_pkg::PROD_W'(aqim_pkg::SEG_RECIP[p][work_i.lane[p].seg]);
        num1_q[p]  <= work_i.lane[p].num;
        base1_q[p] <= work_i.lane[p].base;
        seg1_q[p]  <= work_i.lane[p].seg;

        quo2_q[p]  <= quo_est[p];
        chk2_q[p]  <= aqim_pkg::NUM_W'(quo_est[p]) *
                      aqim_pkg::NUM_W'(aqim_pkg::SEG_DIV[p][seg1_q[p]]);
        num2_q[p]  <= num1_q[p];
        div2_q[p]  <= aqim_pkg::SEG_DIV[p][seg1_q[p]];
        base2_q[p] <= base1_q[p];

        // estimate may be one short: bump when a full width still fits
        sub3_q[p]  <= base2_q[p] + aqim_pkg::IDX_W'(quo2_q[p])
                      + aqim_pkg::IDX_W'(fix[p]);
      end
    end
  end

  assign out_valid_o        = out_v_q;
  assign index_sixteenths_o = aqim_pkg::OUT_W'(best_q);
  assign over_range_o       = over_q;

endmodule

### rtl/air_quality_index_max_unit.sv
// Channel | Direction | Handshake                      | Word
// --------+-----------+--------------------------------+--------------------------------
// in      | input     | in_valid_i / in_stall_o        | five concentrations
// out     | output    | out_valid_o / out_stall_i      | index_sixteenths_o, over_range_o
//
// Takes one sample per cycle while in_stall_o is low; each sample gives one result word.
// Unstalled, an accepted sample passes through the four-entry queue, then three
// arithmetic stages (reciprocal multiply, check multiply, correct-and-add) and
// the max register to the result on the ports.
// Reset clears queue pointers and stage valids; no state survives a sample.
// An out stall with a result word waiting freezes the back stages; in_stall_o rises only when the queue fills.
module air_quality_index_max_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [aqim_pkg::CONC_W-1:0]  so2_ugm3_i,
  input  logic [aqim_pkg::CONC_W-1:0]  no2_ugm3_i,
  input  logic [aqim_pkg::CONC_W-1:0]  pm10_ugm3_i,
  input  logic [aqim_pkg::CO_W-1:0]    co_tenth_mgm3_i,
  input  logic [aqim_pkg::CONC_W-1:0]  pm25_ugm3_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [aqim_pkg::OUT_W-1:0]   index_sixteenths_o,
  output logic                         over_range_o
);

  aqim_pkg::work_t front_word;
  aqim_pkg::work_t back_word;
  logic            queue_full;
  logic            queue_valid;
  logic            back_pop;

  aqim_front u_front (
    .so2_ugm3_i      (so2_ugm3_i),
    .no2_ugm3_i      (no2_ugm3_i),
    .pm10_ugm3_i     (pm10_ugm3_i),
    .co_tenth_mgm3_i (co_tenth_mgm3_i),
    .pm25_ugm3_i     (pm25_ugm3_i),
    .work_o          (front_word)
  );

  aqim_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_word_i (front_word),
    .full_o      (queue_full),
    .pop_i       (back_pop),
    .valid_o     (queue_valid),
    .pop_word_o  (back_word)
  );

  aqim_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (queue_valid),
    .work_i             (back_word),
    .pop_o              (back_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .index_sixteenths_o (index_sixteenths_o),
    .over_range_o       (over_range_o)
  );

  assign in_stall_o = queue_full;

endmodule

### dv/tb_air_quality_index_max_unit.sv
`timescale 1ns / 1ps

module tb_air_quality_index_max_unit;

  localparam int N_RANDOM       = 550;
  localparam int MAX_GAP        = 10;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AT_RESULT = 180;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  localparam int unsigned CONC_KNEE [aqim_pkg::NUM_POLL][aqim_pkg::NUM_BP] = '{
    '{0, 50, 150, 475, 800, 1600, 2100, 2620},
    '{0, 40, 80,  180, 280, 565,  750,  940},
    '{0, 50, 150, 250, 350, 420,  500,  600},
    '{0, 20, 40,  140, 240, 360,  480,  600},
    '{0, 35, 75,  115, 150, 250,  350,  500}
  };
  localparam int unsigned INDEX_KNEE [aqim_pkg::NUM_BP] =
    '{0, 50, 100, 150, 200, 300, 400, 500};
  localparam int unsigned CONC_MAX [aqim_pkg::NUM_POLL] = '{4095, 4095, 4095, 1023, 4095};

  typedef struct packed {
    logic [aqim_pkg::CONC_W-1:0] so2;
    logic [aqim_pkg::CONC_W-1:0] no2;
    logic [aqim_pkg::CONC_W-1:0] pm10;
    logic [aqim_pkg::CO_W-1:0]   co;
    logic [aqim_pkg::CONC_W-1:0] pm25;
  } conc_set_t;

  typedef struct packed {
    logic [aqim_pkg::OUT_W-1:0] index_sixteenths;
    logic                       over_range;
  } aqi_word_t;

  typedef struct packed {
    conc_set_t conc;
    logic      known;
    aqi_word_t word;
  } dir_row_t;

  // so2, no2, pm10, co, pm25 | known result | index, over-range
  localparam dir_row_t DIR_TAB [23] = '{
    '{'{12'd0,    12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd0,    1'b0}},
    '{'{12'd4095, 12'd4095, 12'd4095, 10'd1023, 12'd4095}, 1'b1, '{13'd8000, 1'b1}},
    '{'{12'd2620, 12'd940,  12'd600,  10'd600,  12'd500},  1'b1, '{13'd8000, 1'b0}},
    '{'{12'd2621, 12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd0,    12'd941,  12'd0,    10'd0,    12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd0,    12'd0,    12'd601,  10'd0,    12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd0,    12'd0,    12'd0,    10'd601,  12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd0,    12'd0,    12'd0,    10'd0,    12'd501},  1'b1, '{13'd8000, 1'b1}},
    '{'{12'd1,    12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd16,   1'b0}},
    '{'{12'd0,    12'd0,    12'd0,    10'd20,   12'd0},    1'b1, '{13'd800,  1'b0}},
    '{'{12'd0,    12'd0,    12'd0,    10'd0,    12'd35},   1'b1, '{13'd800,  1'b0}},
    '{'{12'd2100, 12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd6400, 1'b0}},
    '{'{12'd2101, 12'd0,    12'd0,    10'd0,    12'd0},    1'b0, '{13'd0,    1'b0}},
    '{'{12'd2110, 12'd0,    12'd0,    10'd0,    12'd0},    1'b0, '{13'd0,    1'b0}},
    '{'{12'd2619, 12'd0,    12'd0,    10'd0,    12'd0},    1'b0, '{13'd0,    1'b0}},
    '{'{12'd1,    12'd1,    12'd1,    10'd1,    12'd1},    1'b0, '{13'd0,    1'b0}},
    '{'{12'd50,   12'd40,   12'd50,   10'd20,   12'd35},   1'b1, '{13'd800,  1'b0}},
    '{'{12'd51,   12'd41,   12'd51,   10'd21,   12'd36},   1'b0, '{13'd0,    1'b0}},
    '{'{12'd800,  12'd280,  12'd350,  10'd240,  12'd150},  1'b1, '{13'd3200, 1'b0}},
    '{'{12'd4095, 12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd0,    12'd0,    12'd0,    10'd1023, 12'd0},    1'b1, '{13'd8000, 1'b1}},
    '{'{12'd1234, 12'd567,  12'd345,  10'd123,  12'd234},  1'b0, '{13'd0,    1'b0}},
    '{'{12'd0,    12'd0,    12'd0,    10'd0,    12'd0},    1'b1, '{13'd0,    1'b0}}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [aqim_pkg::OUT_W-1:0]  index_sixteenths_o;
  logic                        over_range_o;

  conc_set_t         in_conc;
  logic              row_known;
  aqi_word_t         row_word;

  aqi_word_t         pending_aqi_q [$];
  int                mismatch_count;
  int                n_accepted;
  int                n_results;
  int                n_over;
  int                idle_cycles;

  air_quality_index_max_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .so2_ugm3_i         (in_conc.so2),
    .no2_ugm3_i         (in_conc.no2),
    .pm10_ugm3_i        (in_conc.pm10),
    .co_tenth_mgm3_i    (in_conc.co),
    .pm25_ugm3_i        (in_conc.pm25),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .index_sixteenths_o (index_sixteenths_o),
    .over_range_o       (over_range_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Largest piecewise-linear sub-index of the five pollutants, truncated.
  function automatic aqi_word_t aqi_of(conc_set_t cs);
    int unsigned c [aqim_pkg::NUM_POLL];
    int unsigned scale;
    int unsigned best;
    int unsigned sub;
    int unsigned k;
    aqi_word_t   w;
    c[0] = int'(cs.so2);
    c[1] = int'(cs.no2);
    c[2] = int'(cs.pm10);
    c[3] = int'(cs.co);
    c[4] = int'(cs.pm25);
    scale = 1 << aqim_pkg::FRAC_BITS;
    best = 0;
    w.over_range = 1'b0;
    for (int p = 0; p < aqim_pkg::NUM_POLL; p++) begin
      if (c[p] == 0) begin
        sub = 0;
      end else if (c[p] > CONC_KNEE[p][aqim_pkg::NUM_BP-1]) begin
        sub = INDEX_KNEE[aqim_pkg::NUM_BP-1] * scale;
        w.over_range = 1'b1;
      end else begin
        // a value on a breakpoint belongs to the segment below it
        k = 0;
        while (c[p] > CONC_KNEE[p][k+1]) k++;
        sub = INDEX_KNEE[k] * scale
            + scale * (INDEX_KNEE[k+1] - INDEX_KNEE[k]) * (c[p] - CONC_KNEE[p][k])
              / (CONC_KNEE[p][k+1] - CONC_KNEE[p][k]);
      end
      if (sub > best) best = sub;
    end
    w.index_sixteenths = best[aqim_pkg::OUT_W-1:0];
    return w;
  endfunction

  function automatic int unsigned draw_conc(int p);
    int unsigned top;
    int unsigned mode;
    int unsigned c;
    top = CONC_KNEE[p][aqim_pkg::NUM_BP-1];
    mode = $urandom_range(99, 0);
    if (mode < 8) begin
      c = 0;
    end else if (mode < 14) begin
      c = $urandom_range(CONC_MAX[p], top + 1);
    end else if (mode < 20) begin
      c = $urandom_range(CONC_MAX[p], 0);
    end else if (mode < 45) begin
      // land on a breakpoint or one either side of it
      c = CONC_KNEE[p][$urandom_range(aqim_pkg::NUM_BP - 1, 1)] + $urandom_range(2, 0) - 1;
    end else begin
      c = $urandom_range(top, 1);
    end
    return c;
  endfunction

  task automatic send_word(conc_set_t cs, logic known, aqi_word_t word, int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_conc    = cs;
    row_known  = known;
    row_word   = word;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_pause();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (pending_aqi_q.size() != 0);
  endtask

  // Check results against the oldest expectation, then record new words.
  always @(posedge clk_i) begin
    aqi_word_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        n_results++;
        if (over_range_o) n_over++;
        if (pending_aqi_q.size() == 0) begin
          $error("unexpected word: index_sixteenths %0d over_range %0b",
                 index_sixteenths_o, over_range_o);
          mismatch_count++;
        end else begin
          want = pending_aqi_q.pop_front();
          if (index_sixteenths_o !== want.index_sixteenths) begin
            $error("index_sixteenths: expected %0d, got %0d",
                   want.index_sixteenths, index_sixteenths_o);
            mismatch_count++;
          end
          if (over_range_o !== want.over_range) begin
            $error("over_range: expected %0b, got %0b", want.over_range, over_range_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        n_accepted++;
        pending_aqi_q.push_back(row_known ? row_word : aqi_of(in_conc));
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold, and a stretch with no stalls.
  initial begin
    int got;
    int w;
    got = 0;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (got == HOLD_AT_RESULT) begin
        w = LONG_HOLD;
      end else if (got >= 300 && got < 360) begin
        w = 0;
      end else begin
        w = $urandom_range(MAX_GAP, 0);
      end
      if (w > 0) begin
        out_stall_i = 1'b1;
        repeat (w) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      got++;
      @(negedge clk_i);
    end
  end

  initial begin
    conc_set_t cs;
    int        gap;
    mismatch_count = 0;
    n_accepted     = 0;
    n_results      = 0;
    n_over         = 0;
    idle_cycles    = 0;
    in_valid_i     = 1'b0;
    in_conc        = '0;
    row_known      = 1'b0;
    row_word       = '0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_TAB[i]) begin
      send_word(DIR_TAB[i].conc, DIR_TAB[i].known, DIR_TAB[i].word,
                $urandom_range(MAX_GAP, 0));
    end
    drain_pause();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) drain_pause();
      cs.so2  = aqim_pkg::CONC_W'(draw_conc(0));
      cs.no2  = aqim_pkg::CONC_W'(draw_conc(1));
      cs.pm10 = aqim_pkg::CONC_W'(draw_conc(2));
      cs.co   = aqim_pkg::CO_W'(draw_conc(3));
      cs.pm25 = aqim_pkg::CONC_W'(draw_conc(4));
      // keep offering back to back while the result side holds off
      if ((i >= 150 && i < 280) || (i >= 420 && i < 470)) begin
        gap = 0;
      end else begin
        gap = $urandom_range(MAX_GAP, 0);
      end
      send_word(cs, 1'b0, '0, gap);
    end
    in_valid_i = 1'b0;

    while (pending_aqi_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples (%0d from the directed table), checked %0d results,",
             n_accepted, $size(DIR_TAB), n_results);
    $display("%0d of them flagged over range; %0d mismatches.", n_over, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
